[design/cbc_pkg.sv]
package cbc_pkg;

   localparam int FRAME_COLS  = 40;
   localparam int NUM_CLASSES = 3;

   localparam int LEVEL_W  = 8;
   localparam int COL_W    = 6;
   localparam int TALLY_W  = 12;
   localparam int CSUM_W   = 17;
   localparam int OFFSET_W = 8;
   localparam int CLS_W    = 2;

   // dividend is |5 * (20*count - sum)|, at most 5 * 131071
   localparam int DIVIDEND_W = 20;
   localparam int STEP_W     = 5;
   localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
   localparam logic [CSUM_W-1:0]  CSUM_MAX  = {CSUM_W{1'b1}};
   localparam logic [6:0]         OFFSET_LIMIT = 7'd100;

   // class codes, also the index into per-class vectors
   localparam logic [CLS_W-1:0] CLS_RED   = 2'd0;
   localparam logic [CLS_W-1:0] CLS_GREEN = 2'd1;
   localparam logic [CLS_W-1:0] CLS_BLUE  = 2'd2;

   // color rule thresholds and weights
   localparam logic [LEVEL_W-1:0] RED_MIN_R     = 8'd108;
   localparam logic [12:0]        RED_WR        = 13'd13;
   localparam logic [12:0]        RED_WG        = 13'd19;
   localparam logic [12:0]        RED_WB        = 13'd17;
   localparam logic [LEVEL_W-1:0] GRN_MAX_R     = 8'd160;
   localparam logic [LEVEL_W-1:0] GRN_MIN_G     = 8'd112;
   localparam logic [LEVEL_W-1:0] GRN_MAX_B     = 8'd200;
   localparam logic [12:0]        GRN_WG        = 13'd12;
   localparam logic [12:0]        GRN_WR        = 13'd16;
   localparam logic [12:0]        GRN_WB        = 13'd14;
   localparam logic [LEVEL_W-1:0] BLU_MAX_R     = 8'd160;
   localparam logic [LEVEL_W-1:0] BLU_MAX_G     = 8'd200;
   localparam logic [LEVEL_W-1:0] BLU_MIN_B     = 8'd104;
   localparam logic [8:0]         BLU_MARGIN    = 9'd24;

   typedef struct packed {
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic [COL_W-1:0]   column;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic [TALLY_W-1:0]        red_count;
      logic signed [OFFSET_W-1:0] red_offset;
      logic [TALLY_W-1:0]        green_count;
      logic signed [OFFSET_W-1:0] green_offset;
      logic [TALLY_W-1:0]        blue_count;
      logic signed [OFFSET_W-1:0] blue_offset;
   } rsp_type;

   // per-frame totals handed from front to back
   typedef struct packed {
      logic [NUM_CLASSES-1:0][TALLY_W-1:0] count;
      logic [NUM_CLASSES-1:0][CSUM_W-1:0]  csum;
   } snap_type;

endpackage

[design/cbc_front.sv]
module cbc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cbc_pkg::req_type  req,
   input  logic              q_full,
   output logic              q_push,
   output cbc_pkg::snap_type q_data
);
   import cbc_pkg::*;

   logic [NUM_CLASSES-1:0][TALLY_W-1:0] tally_ff, tally_in, tally_upd;
   logic [NUM_CLASSES-1:0][CSUM_W-1:0]  csum_ff, csum_in, csum_upd;
   logic [NUM_CLASSES-1:0]              hit;
   logic [12:0] r13, g13, b13;
   logic [8:0]  b9, r24, g24;
   logic [CSUM_W:0] csum_sum;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      r13 = 13'(req.red_level);
      g13 = 13'(req.green_level);
      b13 = 13'(req.blue_level);
      b9  = 9'(req.blue_level);
      r24 = 9'(req.red_level) + BLU_MARGIN;
      g24 = 9'(req.green_level) + BLU_MARGIN;

      hit[CLS_RED] = (req.red_level >= RED_MIN_R) &&
                     (r13 * RED_WR >= g13 * RED_WG) &&
                     (r13 * RED_WR >= b13 * RED_WB);
      hit[CLS_GREEN] = (req.red_level < GRN_MAX_R) && (req.green_level >= GRN_MIN_G) &&
                       (req.blue_level < GRN_MAX_B) &&
                       (g13 * GRN_WG >= r13 * GRN_WR) &&
                       (g13 * GRN_WG >= b13 * GRN_WB);
      hit[CLS_BLUE] = (req.red_level < BLU_MAX_R) && (req.green_level < BLU_MAX_G) &&
                      (req.blue_level >= BLU_MIN_B) && (b9 >= r24) && (b9 > g24);
   end

   // saturating accumulate
   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         tally_upd[i] = tally_ff[i];
         csum_upd[i]  = csum_ff[i];
         csum_sum     = (CSUM_W + 1)'(csum_ff[i]) + (CSUM_W + 1)'(req.column);
         if (hit[i]) begin
            if (tally_ff[i] != TALLY_MAX) tally_upd[i] = tally_ff[i] + 1'b1;
            csum_upd[i] = csum_sum[CSUM_W] ? CSUM_MAX : csum_sum[CSUM_W-1:0];
         end
      end
   end

   assign q_data.count = tally_upd;
   assign q_data.csum  = csum_upd;
   assign q_push       = accept && req.frame_end;

   always_comb begin
      tally_in = tally_ff;
      csum_in  = csum_ff;
      if (accept) begin
         if (req.frame_end) begin
            tally_in = '0;
            csum_in  = '0;
         end else begin
            tally_in = tally_upd;
            csum_in  = csum_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
         csum_ff  <= '0;
      end else begin
         tally_ff <= tally_in;
         csum_ff  <= csum_in;
      end
   end

endmodule

[design/cbc_queue.sv]
module cbc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cbc_pkg::snap_type push_data,
   output logic              full,
   input  logic              pop,
   output cbc_pkg::snap_type head,
   output logic              empty
);
   import cbc_pkg::*;

   snap_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/cbc_back.sv]
module cbc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cbc_pkg::snap_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cbc_pkg::rsp_type  rsp
);
   import cbc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_DIV, ST_DONE} state_type;

   state_type                            state_ff;
   snap_type                             snap_ff;
   logic [CLS_W-1:0]                     cls_ff;
   logic [STEP_W-1:0]                    step_ff;
   logic [DIVIDEND_W-1:0]                div_ff;
   logic [TALLY_W-1:0]                   rem_ff;
   logic                                 neg_ff;
   logic [NUM_CLASSES-1:0][OFFSET_W-1:0] offs_ff;
   logic                                 rsp_valid_ff;
   rsp_type                              rsp_ff;

   logic [TALLY_W-1:0]    cur_count;
   logic [18:0]           cnt20, diff;
   logic [17:0]           mag;
   logic [DIVIDEND_W-1:0] mag5, div_next;
   logic [TALLY_W:0]      rem_shift;
   logic                  ge;
   logic [TALLY_W-1:0]    rem_next;
   logic [6:0]            q_clamp;
   logic [OFFSET_W-1:0]   offset;

   assign cur_count = snap_ff.count[cls_ff];

   // dividend setup: 20*count - sum, then magnitude times five
   always_comb begin
      cnt20 = (19'(cur_count) << 4) + (19'(cur_count) << 2);
      diff  = cnt20 - 19'(snap_ff.csum[cls_ff]);
      mag   = diff[18] ? 18'(-diff) : diff[17:0];
      mag5  = (DIVIDEND_W'(mag) << 2) + DIVIDEND_W'(mag);
   end

   // one restoring division step per cycle
   always_comb begin
      rem_shift = {rem_ff, div_ff[DIVIDEND_W-1]};
      ge        = rem_shift >= {1'b0, cur_count};
      rem_next  = ge ? TALLY_W'(rem_shift - {1'b0, cur_count}) : rem_shift[TALLY_W-1:0];
      div_next  = {div_ff[DIVIDEND_W-2:0], ge};
      q_clamp   = (div_next > DIVIDEND_W'(OFFSET_LIMIT)) ? OFFSET_LIMIT : div_next[6:0];
      if (cur_count == '0)
         offset = '0;
      else if (neg_ff)
         offset = OFFSET_W'(-{1'b0, q_clamp});
      else
         offset = {1'b0, q_clamp};
   end

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // ST_DONE handles the output valid itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  snap_ff  <= q_head;
                  cls_ff   <= CLS_RED;
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               div_ff   <= mag5;
               neg_ff   <= diff[18];
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               div_ff  <= div_next;
               rem_ff  <= rem_next;
               step_ff <= step_ff + 1'b1;
               if (step_ff == DIV_LAST_STEP) begin
                  offs_ff[cls_ff] <= offset;
                  if (cls_ff == CLS_BLUE) begin
                     state_ff <= ST_DONE;
                  end else begin
                     cls_ff   <= cls_ff + 1'b1;
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.red_count    <= snap_ff.count[CLS_RED];
                  rsp_ff.red_offset   <= offs_ff[CLS_RED];
                  rsp_ff.green_count  <= snap_ff.count[CLS_GREEN];
                  rsp_ff.green_offset <= offs_ff[CLS_GREEN];
                  rsp_ff.blue_count   <= snap_ff.count[CLS_BLUE];
                  rsp_ff.blue_offset  <= offs_ff[CLS_BLUE];
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[design/color_blob_centroid.sv]
// Channel  Direction  Beat                           Accepted when
// req      in         one pixel (levels, column, eof) req_valid && !req_stall
// rsp      out        one frame result (3 x count, offset) rsp_valid && !rsp_stall
//
// Pixels are taken one per clock while req_stall is low; each frame-end
// beat yields one rsp beat. The back end pops a frame from the queue, runs
// the shared 20-step divider once per class in turn (a setup state, then 20
// steps), and registers the result beat; it pops the next frame only after
// that beat is registered, which waits while rsp is stalled.
// req_stall rises only when two finished frames wait in the queue, i.e. when
// frame ends come faster than the back end retires them or rsp is held off.
// Synchronous reset clears the accumulators, the queue and the output valid.
module color_blob_centroid (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cbc_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbc_pkg::rsp_type rsp
);
   import cbc_pkg::*;

   // front -> queue
   logic     q_push;
   snap_type q_push_data;
   logic     q_full;
   // queue -> back
   logic     q_pop;
   snap_type q_head;
   logic     q_empty;

   // front: classify each pixel, accumulate, snapshot totals at frame end
   cbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // two-entry queue of frame totals so the next frame keeps streaming
   cbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // back: serial divide per class, clamp, register the result beat
   cbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule
